[hw/rtl/psfp_pkg.sv]
// Shared types and constants for the particulate sensor frame parser.
// No dependencies; compile first.
`default_nettype none

package psfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h42;
   localparam logic [7:0] HDR_SECOND = 8'h4D;
   localparam logic [7:0] LEN_SHORT  = 8'(2 * 9 + 2);
   localparam logic [7:0] LEN_LONG   = 8'(2 * 13 + 2);

   localparam int PAYLOAD_BYTES = 12;
   localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
   localparam int POS_W         = 5;

   // first payload byte sits at this frame position
   localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd4;

   // work codes handed from front to back
   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_ADD_STORE = 3'd2;
   localparam logic [2:0] OP_CHK_HI    = 3'd3;
   localparam logic [2:0] OP_CHK_LO    = 3'd4;

   typedef struct packed {
      logic [2:0]       op;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } entry_type;

   typedef struct packed {
      logic [15:0] pm1_standard;
      logic [15:0] pm25_standard;
      logic [15:0] pm10_standard;
      logic [15:0] pm1_atmospheric;
      logic [15:0] pm25_atmospheric;
      logic [15:0] pm10_atmospheric;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/psfp_if.sv]
// Valid/ready channel interfaces for the frame parser: received bytes in,
// decoded concentrations out. No dependencies.
`default_nettype none

interface psfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pm1_standard;
   logic [15:0] pm25_standard;
   logic [15:0] pm10_standard;
   logic [15:0] pm1_atmospheric;
   logic [15:0] pm25_atmospheric;
   logic [15:0] pm10_atmospheric;

   modport source (output valid, output pm1_standard, output pm25_standard,
                   output pm10_standard, output pm1_atmospheric,
                   output pm25_atmospheric, output pm10_atmospheric,
                   input ready);
   modport sink   (input valid, input pm1_standard, input pm25_standard,
                   input pm10_standard, input pm1_atmospheric,
                   input pm25_atmospheric, input pm10_atmospheric,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/psfp_front.sv]
// Front end: tracks frame position and length, tags each frame byte with a work code.
// Depends on psfp_pkg.
`default_nettype none

module psfp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                req_ready,
   output logic                     push_valid,
   output psfp_pkg::entry_type      push_entry
);

   logic [psfp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       long_ff, long_in;
   logic                       hi_zero_ff, hi_zero_in;
   logic                       accept;
   logic [psfp_pkg::POS_W-1:0] chk_hi_pos;
   logic [psfp_pkg::POS_W-1:0] pay_off;

   assign accept     = req_valid && req_ready;
   assign chk_hi_pos = long_ff ? psfp_pkg::POS_W'(psfp_pkg::LEN_LONG + 8'd2)
                               : psfp_pkg::POS_W'(psfp_pkg::LEN_SHORT + 8'd2);
   assign pay_off    = pos_ff - psfp_pkg::POS_PAYLOAD;

   always_comb begin
      pos_in          = pos_ff;
      long_in         = long_ff;
      hi_zero_in      = hi_zero_ff;
      push_valid      = 1'b0;
      push_entry.op   = psfp_pkg::OP_ADD;
      push_entry.idx  = pay_off[psfp_pkg::IDX_W-1:0];
      push_entry.data = req_rx_byte;
      if (accept) begin
         case (pos_ff)
            5'd0: begin
               if (req_rx_byte == psfp_pkg::HDR_FIRST) begin
                  push_valid    = 1'b1;
                  push_entry.op = psfp_pkg::OP_START;
                  pos_in        = 5'd1;
               end
            end
            5'd1: begin
               // a wrong second byte is not retried as a first byte
               if (req_rx_byte == psfp_pkg::HDR_SECOND) begin
                  push_valid = 1'b1;
                  pos_in     = 5'd2;
               end else begin
                  pos_in = '0;
               end
            end
            5'd2: begin
               push_valid = 1'b1;
               hi_zero_in = (req_rx_byte == 8'd0);
               pos_in     = 5'd3;
            end
            5'd3: begin
               if (hi_zero_ff && (req_rx_byte == psfp_pkg::LEN_SHORT ||
                                  req_rx_byte == psfp_pkg::LEN_LONG)) begin
                  push_valid = 1'b1;
                  long_in    = (req_rx_byte == psfp_pkg::LEN_LONG);
                  pos_in     = psfp_pkg::POS_PAYLOAD;
               end else begin
                  pos_in = '0;
               end
            end
            default: begin
               push_valid = 1'b1;
               if (pos_ff == chk_hi_pos) begin
                  push_entry.op = psfp_pkg::OP_CHK_HI;
                  pos_in        = pos_ff + 5'd1;
               end else if (pos_ff == chk_hi_pos + 5'd1) begin
                  push_entry.op = psfp_pkg::OP_CHK_LO;
                  pos_in        = '0;
               end else begin
                  if (pay_off < psfp_pkg::POS_W'(psfp_pkg::PAYLOAD_BYTES)) begin
                     push_entry.op = psfp_pkg::OP_ADD_STORE;
                  end
                  pos_in = pos_ff + 5'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         long_ff    <= 1'b0;
         hi_zero_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         long_ff    <= long_in;
         hi_zero_ff <= hi_zero_in;
      end
   end

   a_lo_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_entry.op == psfp_pkg::OP_CHK_LO) |=> (pos_ff == '0))
      else $error("front: frame position not cleared after checksum");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_entry.op == psfp_pkg::OP_ADD_STORE) |->
      (push_entry.idx < psfp_pkg::IDX_W'(psfp_pkg::PAYLOAD_BYTES)))
      else $error("front: payload index beyond store");

endmodule

`default_nettype wire

[hw/rtl/psfp_queue.sv]
// Small FIFO of tagged bytes between the front and back ends.
// Depends on psfp_pkg.
`default_nettype none

module psfp_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire psfp_pkg::entry_type  push_entry,
   output logic                      full,
   output logic                      head_valid,
   output psfp_pkg::entry_type       head_entry,
   input  wire logic                 pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   psfp_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("queue: push while full, item lost");

endmodule

`default_nettype wire

[hw/rtl/psfp_back.sv]
// Back end: running sum, payload store, checksum compare and result register.
// Depends on psfp_pkg.
`default_nettype none

module psfp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire psfp_pkg::entry_type  head_entry,
   output logic                      pop,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output psfp_pkg::result_type      rsp_result
);

   logic [15:0]          sum_ff, sum_in;
   logic [7:0]           chk_hi_ff, chk_hi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   psfp_pkg::result_type result_ff, result_in;
   logic [7:0]           store_ff [psfp_pkg::PAYLOAD_BYTES];
   logic                 slot_free;
   logic                 match;

   // only the checksum low byte needs the result slot
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = head_valid &&
                      (head_entry.op != psfp_pkg::OP_CHK_LO || slot_free);
   assign match     = pop && head_entry.op == psfp_pkg::OP_CHK_LO &&
                      ({chk_hi_ff, head_entry.data} == sum_ff);

   always_comb begin
      sum_in       = sum_ff;
      chk_hi_in    = chk_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (pop) begin
         case (head_entry.op)
            psfp_pkg::OP_START:     sum_in = {8'd0, head_entry.data};
            psfp_pkg::OP_ADD:       sum_in = sum_ff + {8'd0, head_entry.data};
            psfp_pkg::OP_ADD_STORE: sum_in = sum_ff + {8'd0, head_entry.data};
            psfp_pkg::OP_CHK_HI:    chk_hi_in = head_entry.data;
            default: ;
         endcase
      end
      if (match) begin
         rsp_valid_in               = 1'b1;
         result_in.pm1_standard     = {store_ff[0], store_ff[1]};
         result_in.pm25_standard    = {store_ff[2], store_ff[3]};
         result_in.pm10_standard    = {store_ff[4], store_ff[5]};
         result_in.pm1_atmospheric  = {store_ff[6], store_ff[7]};
         result_in.pm25_atmospheric = {store_ff[8], store_ff[9]};
         result_in.pm10_atmospheric = {store_ff[10], store_ff[11]};
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.op == psfp_pkg::OP_ADD_STORE) begin
         store_ff[head_entry.idx] <= head_entry.data;
      end
      result_ff <= result_in;
      sum_ff    <= sum_in;
      chk_hi_ff <= chk_hi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && head_entry.op == psfp_pkg::OP_CHK_LO))
      else $error("back: result raised without a checksum byte");

   a_start_loads_sum: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.op == psfp_pkg::OP_START) |=>
      (sum_ff == {8'd0, $past(head_entry.data)}))
      else $error("back: running sum not seeded by header byte");

endmodule

`default_nettype wire

[hw/rtl/particulate_sensor_frame_parser_core.sv]
// Top level of the particulate sensor frame parser: front, queue and back.
// Depends on psfp_pkg, psfp_if, psfp_front, psfp_queue, psfp_back.
//
//   Channel   Dir   Handshake        Payload
//   req_ch    in    valid / ready    rx_byte[7:0]
//   rsp_ch    out   valid / ready    six 16-bit concentrations
//
// One byte is taken every cycle while the tag queue has room.
// rsp_ch.valid is registered; it rises once the back end pops a frame's last
// checksum byte and the sum matches, waiting only while an older result is held.
// A held result stalls only the checksum low byte in the back end; the
// queue (QUEUE_DEPTH entries) then fills and req_ch.ready drops.
// Synchronous reset returns the parser to header hunting and empties the queue.
`default_nettype none

module particulate_sensor_frame_parser_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   psfp_req_if.sink      req_ch,
   psfp_rsp_if.source    rsp_ch
);

   psfp_pkg::entry_type  push_entry, head_entry;
   psfp_pkg::result_type result;
   logic                 push_valid, full, head_valid, pop;
   logic                 req_ready;

   assign req_ready    = !full;
   assign req_ch.ready = req_ready;

   psfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_rx_byte (req_ch.rx_byte),
      .req_ready   (req_ready),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   psfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   psfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_result (result)
   );

   assign rsp_ch.pm1_standard     = result.pm1_standard;
   assign rsp_ch.pm25_standard    = result.pm25_standard;
   assign rsp_ch.pm10_standard    = result.pm10_standard;
   assign rsp_ch.pm1_atmospheric  = result.pm1_atmospheric;
   assign rsp_ch.pm25_atmospheric = result.pm25_atmospheric;
   assign rsp_ch.pm10_atmospheric = result.pm10_atmospheric;

endmodule

`default_nettype wire
